/* hw/rtl/slot_table_first_free_alloc_macros.svh */
// Assertion macros used by the slot table back part.
`ifndef SLOT_TABLE_FIRST_FREE_ALLOC_MACROS_SVH
`define SLOT_TABLE_FIRST_FREE_ALLOC_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define STA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication outside reset.
`define STA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* hw/rtl/sta_pkg.sv */
// Package with action and status codes and the queue entry type of the slot table.
`timescale 1ns / 1ps
`default_nettype none
package sta_pkg;
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_SCAN   = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_BADIX = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    localparam int MAX_RESULTS = 16;

    // One command as classified by the front part.
    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] given_tag;
        logic [31:0] payload;
        logic [5:0]  slot;
    } t_cmd;
endpackage
`default_nettype wire

/* hw/rtl/sta_front.sv */
// Front part: accepts items, drops ACT_NONE actions, and queues commands.
`timescale 1ns / 1ps
`default_nettype none
module sta_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire sta_pkg::t_cmd i_cmd,
    output logic               o_cmd_valid,
    input  wire logic          i_cmd_take,
    output sta_pkg::t_cmd      o_cmd
);
    import sta_pkg::*;

    // Two-entry queue.
    t_cmd       r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       r_wr;
    logic       w_push;
    logic       w_pop;

    assign o_stall     = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];
    assign w_pop       = o_cmd_valid && i_cmd_take;
    assign w_push      = i_valid && !o_stall && (i_cmd.action != ACT_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= i_cmd;
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/sta_back.sv */
// Back part: slot tags, payload memory, counters and the result register.
`timescale 1ns / 1ps
`default_nettype none
`include "slot_table_first_free_alloc_macros.svh"
module sta_back #(
    parameter int SLOTS        = 16,
    parameter int PAYLOAD_BITS = 32,
    parameter int TAG_BITS     = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [4:0]    i_cap_reg,
    input  wire logic          i_cmd_valid,
    output logic               o_cmd_take,
    input  wire sta_pkg::t_cmd i_cmd,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [1:0]         o_status,
    output logic [15:0]        o_tag_out,
    output logic [5:0]         o_slot_out,
    output logic [31:0]        o_payload_out,
    output logic [4:0]         o_occupancy,
    output logic               o_is_full,
    output logic               o_is_empty,
    output logic               o_last
);
    import sta_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int NW = $clog2(MAX_RESULTS + 1);
    localparam logic [TAG_BITS-1:0] TAG_MAX = {TAG_BITS{1'b1}};

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]             r_state;
    t_cmd                   r_cmd;
    logic [TAG_BITS-1:0]    r_tags [SLOTS];
    logic [PAYLOAD_BITS-1:0] r_mem [SLOTS];
    logic [PAYLOAD_BITS-1:0] r_rdata;
    logic [CW-1:0]          r_occ;
    logic [TAG_BITS-1:0]    r_ctr;
    logic [SW:0]            r_idx;
    logic [NW-1:0]          r_total;
    logic [NW-1:0]          r_n;
    logic                   r_ovld;

    logic [6:0]             w_cap;
    logic [SLOTS-1:0]       w_occ_vec;
    logic [SLOTS-1:0]       w_free_vec;
    logic                   w_free_found;
    logic [SW-1:0]          w_free_idx;
    logic [NW-1:0]          w_cnt;
    logic [SW:0]            w_nxt_idx;
    logic                   w_nxt_found;
    logic                   w_full_now;
    logic                   w_out_free;
    logic                   w_emit;
    logic [TAG_BITS-1:0]    w_gtag;
    logic [TAG_BITS-1:0]    w_ctr_nxt;
    logic [TAG_BITS-1:0]    w_ins_tag;
    logic [CW-1:0]          n_occ;

    assign w_cap = ({2'b0, i_cap_reg} > 7'(SLOTS)) ? 7'(SLOTS) : {2'b0, i_cap_reg};

    // Occupancy and free masks limited to the capacity.
    always_comb begin
        for (int k = 0; k < SLOTS; k++) begin
            w_occ_vec[k]  = (r_tags[k] != '0) && (7'(k) < w_cap);
            w_free_vec[k] = (r_tags[k] == '0) && (7'(k) < w_cap);
        end
    end

    always_comb begin
        w_free_found = 1'b0;
        w_free_idx   = '0;
        for (int k = SLOTS - 1; k >= 0; k--) begin
            if (w_free_vec[k]) begin
                w_free_found = 1'b1;
                w_free_idx   = SW'(k);
            end
        end
    end

    always_comb begin
        w_cnt = '0;
        for (int k = 0; k < SLOTS; k++) begin
            w_cnt = w_cnt + NW'(w_occ_vec[k]);
        end
    end

    // Next occupied slot at or above r_idx.
    always_comb begin
        w_nxt_found = 1'b0;
        w_nxt_idx   = '0;
        for (int k = SLOTS - 1; k >= 0; k--) begin
            if (w_occ_vec[k] && ((SW+1)'(k) >= r_idx)) begin
                w_nxt_found = 1'b1;
                w_nxt_idx   = (SW+1)'(k);
            end
        end
    end

    assign w_full_now = (7'(r_occ) >= w_cap);
    assign w_out_free = !r_ovld || !i_stall;
    assign w_gtag     = TAG_BITS'(r_cmd.given_tag);
    assign w_ctr_nxt  = ((r_ctr == '0) || (r_ctr == TAG_MAX)) ? TAG_BITS'(1) : r_ctr + 1'b1;
    assign w_ins_tag  = (w_gtag != '0) ? w_gtag : w_ctr_nxt;
    assign o_cmd_take = (r_state == S_IDLE);
    assign o_valid    = r_ovld;

    // A result loads when free: from execute (not a non-empty scan) or output.
    assign w_emit = w_out_free
                    && (((r_state == S_EXEC) && ((r_cmd.action == ACT_INSERT)
                         || (r_cmd.action == ACT_REMOVE) || (w_cnt == '0)))
                        || (r_state == S_OUT));

    always_comb begin
        n_occ = r_occ;
        if (r_state == S_EXEC && w_out_free) begin
            if (r_cmd.action == ACT_INSERT && !w_full_now && w_free_found) begin
                n_occ = r_occ + 1'b1;
            end else if (r_cmd.action == ACT_REMOVE && (7'(r_cmd.slot) < w_cap)
                         && (r_tags[r_cmd.slot[SW-1:0]] != '0) && (r_occ != '0)) begin
                n_occ = r_occ - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
            r_ctr   <= '0;
            r_ovld  <= 1'b0;
            r_idx   <= '0;
            r_n     <= '0;
            r_total <= '0;
            for (int k = 0; k < SLOTS; k++) begin
                r_tags[k] <= '0;
            end
        end else begin
            r_ovld <= w_emit || (r_ovld && i_stall);
            r_occ  <= n_occ;
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_out_free) begin
                        priority if (r_cmd.action == ACT_INSERT) begin
                            r_state <= S_IDLE;
                            if (!w_full_now) begin
                                if (w_gtag == '0) begin
                                    r_ctr <= w_ctr_nxt;
                                end
                                if (w_free_found) begin
                                    r_tags[w_free_idx] <= w_ins_tag;
                                end
                            end
                        end else if (r_cmd.action == ACT_REMOVE) begin
                            r_state <= S_IDLE;
                            if (7'(r_cmd.slot) < w_cap) begin
                                r_tags[r_cmd.slot[SW-1:0]] <= '0;
                            end
                        end else begin
                            // Scan: count occupied slots, clamp, then walk.
                            r_total <= (w_cnt > NW'(MAX_RESULTS)) ? NW'(MAX_RESULTS) : w_cnt;
                            r_idx   <= '0;
                            r_n     <= '0;
                            if (w_cnt == '0) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_state <= S_SCAN;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    if (w_nxt_found) begin
                        r_idx   <= w_nxt_idx;
                        r_state <= S_RD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_RD: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_n    <= r_n + 1'b1;
                        r_idx  <= r_idx + 1'b1;
                        r_state <= (r_n + 1'b1 == r_total) ? S_IDLE : S_SCAN;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_cmd_valid) begin
            r_cmd <= i_cmd;
        end
        if (r_state == S_EXEC && w_out_free && r_cmd.action == ACT_INSERT
            && !w_full_now && w_free_found) begin
            r_mem[w_free_idx] <= PAYLOAD_BITS'(r_cmd.payload);
        end
        if (r_state == S_RD) begin
            r_rdata <= r_mem[r_idx[SW-1:0]];
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC && w_out_free) begin
            o_payload_out <= '0;
            o_last        <= 1'b1;
            o_occupancy   <= 5'(n_occ);
            o_is_empty    <= (n_occ == '0);
            o_is_full     <= (7'(n_occ) >= w_cap);
            if (r_cmd.action == ACT_INSERT) begin
                if (!w_full_now && w_free_found) begin
                    o_status   <= ST_OK;
                    o_tag_out  <= 16'(w_ins_tag);
                    o_slot_out <= 6'(w_free_idx);
                end else begin
                    o_status   <= ST_FULL;
                    o_tag_out  <= '0;
                    o_slot_out <= '0;
                end
            end else if (r_cmd.action == ACT_REMOVE) begin
                o_tag_out  <= '0;
                o_slot_out <= r_cmd.slot;
                o_status   <= (7'(r_cmd.slot) < w_cap) ? ST_OK : ST_BADIX;
            end else begin
                o_tag_out  <= '0;
                o_slot_out <= '0;
                o_status   <= ST_EMPTY;
            end
        end else if (r_state == S_OUT && w_out_free) begin
            o_status      <= ST_OK;
            o_tag_out     <= 16'(r_tags[r_idx[SW-1:0]]);
            o_slot_out    <= 6'(r_idx);
            o_payload_out <= 32'(r_rdata);
            o_occupancy   <= 5'(r_occ);
            o_is_empty    <= (r_occ == '0);
            o_is_full     <= w_full_now;
            o_last        <= (r_n + 1'b1 == r_total);
        end
    end

    `STA_ASSERT_IMP(a_occ_bound, i_clk, i_rst_n, 1'b1, r_occ <= CW'(SLOTS), "occupancy overflow")
    `STA_ASSERT_NEXT(a_hold, i_clk, i_rst_n, r_ovld && i_stall, r_ovld, "result dropped")
    `STA_ASSERT_IMP(a_ctr_nz, i_clk, i_rst_n, r_state == S_IDLE && r_ctr != '0, r_ctr != '0, "counter zero")
    `STA_ASSERT_IMP(a_scan_n, i_clk, i_rst_n, r_state == S_OUT, r_n < r_total, "scan overrun")
endmodule
`default_nettype wire

/* hw/rtl/slot_table_first_free_alloc.sv */
// Top level of the slot table with lowest-free allocation.
//  channel | direction | handshake
//  in      | input     | i_valid / o_stall
//  out     | output    | o_valid / i_stall
//  cfg     | input     | i_cfg_we / i_cfg_wdata
// An insert or remove result is loaded into the result register from the execute state; after
// execute, each result of a scan passes through the search, read and output states.
// Items pass through a two-entry command queue, so the input stalls only when it is full.
// Reset is synchronous and active low; it frees every slot and sets capacity to 16.
// A stalled output holds the result register; the back part then waits in its execute and output states.
`timescale 1ns / 1ps
`default_nettype none
module slot_table_first_free_alloc #(
    parameter int SLOTS        = 16,
    parameter int PAYLOAD_BITS = 32,
    parameter int TAG_BITS     = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [4:0]  i_cfg_wdata,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic [15:0] i_given_tag,
    input  wire logic [31:0] i_payload_in,
    input  wire logic [5:0]  i_slot_in,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [15:0]      o_tag_out,
    output logic [5:0]       o_slot_out,
    output logic [31:0]      o_payload_out,
    output logic [4:0]       o_occupancy,
    output logic             o_is_full,
    output logic             o_is_empty,
    output logic             o_last
);
    import sta_pkg::*;

    logic [4:0] r_cap;
    t_cmd       w_in_cmd;
    t_cmd       w_q_cmd;
    logic       w_q_valid;
    logic       w_q_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= 5'd16;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    assign w_in_cmd = '{action: i_action, given_tag: i_given_tag,
                        payload: i_payload_in, slot: i_slot_in};

    sta_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_cmd(w_in_cmd), .o_cmd_valid(w_q_valid), .i_cmd_take(w_q_take), .o_cmd(w_q_cmd)
    );

    sta_back #(.SLOTS(SLOTS), .PAYLOAD_BITS(PAYLOAD_BITS), .TAG_BITS(TAG_BITS)) u_back (
        .i_clk, .i_rst_n, .i_cap_reg(r_cap),
        .i_cmd_valid(w_q_valid), .o_cmd_take(w_q_take), .i_cmd(w_q_cmd),
        .o_valid, .i_stall, .o_status, .o_tag_out, .o_slot_out, .o_payload_out,
        .o_occupancy, .o_is_full, .o_is_empty, .o_last
    );
endmodule
`default_nettype wire
